### hw/rtl/nmea_sentence_checker_top_macros.svh
// Assertion helpers used by the checker's parser.
`ifndef NMEA_SENTENCE_CHECKER_TOP_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NMEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/nmea_chk_pkg.sv
package nmea_chk_pkg;

  localparam int LINE_MAX = 127;
  localparam int LEN_W = $clog2(LINE_MAX + 1);

  typedef struct packed {
    logic       new_window;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic               sentence_valid;
    logic               is_position_fix;
    logic [15:0]        valid_count;
    logic signed [14:0] satellites;
    logic signed [14:0] fix_quality;
  } result_t;

  typedef struct packed {
    logic take;
    logic produce;
  } core_ctrl_t;

endpackage

### hw/rtl/nmea_sentence_checker_top.sv
// Checks receiver text lines one byte per transfer and gives one result per
// finished non-empty line. A new byte is taken in every cycle unless the input
// stalls; the input register, the line parser and the result register form two
// stages: the line-ending byte passes the input register, then the parser loads
// its result into the result register. The input stalls only when a line ends
// while an untaken result is held; other bytes still go in while it waits.
module nmea_sentence_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,  // [0] new_window
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [15:0] valid_count, [30:16] satellites,
                                     // [45:31] fix_quality, [47:46] zero
  output logic [1:0]  m_axis_tuser   // [0] sentence_valid, [1] is_position_fix
);
  import nmea_chk_pkg::*;

  core_ctrl_t ctrl;
  in_item_t   item;
  result_t    result;
  logic       item_valid;
  logic       out_space;

  nmea_chk_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .ctrl          (ctrl),
    .item_valid    (item_valid),
    .item          (item)
  );

  nmea_chk_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_space  (out_space),
    .ctrl       (ctrl),
    .result     (result)
  );

  nmea_chk_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .result        (result),
    .out_space     (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### hw/rtl/nmea_chk_in_stage.sv
module nmea_chk_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic [0:0]            s_axis_tuser,
  input  nmea_chk_pkg::core_ctrl_t ctrl,
  output logic                  item_valid,
  output nmea_chk_pkg::in_item_t item
);
  import nmea_chk_pkg::*;

  logic item_valid_next;
  logic accept;

  assign s_axis_tready = !item_valid || ctrl.take;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_valid_next = item_valid;
    if (accept) begin
      item_valid_next = 1'b1;
    end else if (ctrl.take) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte  <= s_axis_tdata;
      item.new_window <= s_axis_tuser[0];
    end
  end

endmodule

### hw/rtl/nmea_chk_parser.sv
`include "nmea_sentence_checker_top_macros.svh"

module nmea_chk_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  nmea_chk_pkg::in_item_t   item,
  input  logic                     out_space,
  output nmea_chk_pkg::core_ctrl_t ctrl,
  output nmea_chk_pkg::result_t    result
);
  import nmea_chk_pkg::*;

  localparam logic [7:0]  CHAR_NUL    = 8'h00;
  localparam logic [7:0]  CHAR_LF     = 8'h0A;
  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
  localparam logic [7:0]  CHAR_STAR   = 8'h2A;
  localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
  localparam logic [7:0]  CHAR_0      = 8'h30;
  localparam logic [7:0]  CHAR_9      = 8'h39;
  localparam logic [23:0] TAG_GGA     = 24'h474741;
  localparam logic [13:0] NUM_SAT     = 14'd9999;
  localparam logic [2:0]  FIELD_FIX   = 3'd6;
  localparam logic [2:0]  FIELD_SATS  = 3'd7;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX);

  typedef struct packed {
    logic        cand;
    logic        active;
    logic [13:0] num;
  } field_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             text_ended;
    logic             dollar;
    logic             star;
    logic [1:0]       after_star;
    logic [7:0]       xor_sum;
    logic [30:0]      hex;
    logic             hex_active;
    logic             hex_ovf;
    logic [23:0]      tag;
    logic             tag_found;
    logic [2:0]       commas;
    field_t           f6;
    field_t           f7;
  } line_t;

  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic field_t dec_step(field_t f, logic [7:0] c);
    field_t     r;
    logic [17:0] v;
    r = f;
    v = ({4'd0, f.num} << 3) + ({4'd0, f.num} << 1) + {14'd0, c[3:0]};
    if (f.active) begin
      if (c < CHAR_0 || c > CHAR_9) begin
        r.active = 1'b0;
      end else begin
        r.num = (v > {4'd0, NUM_SAT}) ? NUM_SAT : v[13:0];
      end
    end
    return r;
  endfunction

  line_t              lstate;
  line_t              lstate_next;
  line_t              cur;
  logic [15:0]        sentence_counter;
  logic [15:0]        sentence_counter_next;
  logic signed [14:0] satellites_held;
  logic signed [14:0] satellites_held_next;
  logic signed [14:0] fix_held;
  logic signed [14:0] fix_held_next;
  logic [15:0]        cnt_cur;
  logic [7:0]         c;
  logic [4:0]         hd;
  logic [7:0]         hex_byte;
  logic               is_eol;
  logic               valid;
  logic               gga;
  field_t             f6;

  always_comb begin
    cur     = item.new_window ? '0 : lstate;
    cnt_cur = item.new_window ? 16'd0 : sentence_counter;
    c       = item.data_byte;
    hd      = hex_decode(c);
    is_eol  = (c == CHAR_CR) || (c == CHAR_LF);

    ctrl.produce = is_eol && (cur.len != '0);
    ctrl.take    = item_valid && (!ctrl.produce || out_space);

    lstate_next           = cur;
    sentence_counter_next = cnt_cur;
    satellites_held_next  = satellites_held;
    fix_held_next         = fix_held;
    f6                    = cur.f6;

    hex_byte = cur.hex_ovf ? 8'hFF : cur.hex[7:0];
    valid    = cur.dollar && cur.star && cur.after_star[1] && (hex_byte == cur.xor_sum);
    gga      = valid && cur.tag_found;

    if (!is_eol) begin
      if (cur.len < LEN_LIMIT) begin
        lstate_next.len = cur.len + 1'b1;
        if (!cur.text_ended) begin
          if (c == CHAR_NUL) begin
            lstate_next.text_ended = 1'b1;
          end else begin
            if (cur.len == '0) begin
              lstate_next.dollar = (c == CHAR_DOLLAR);
            end else if (!cur.star) begin
              if (c == CHAR_STAR) begin
                lstate_next.star       = 1'b1;
                lstate_next.hex_active = 1'b1;
                lstate_next.hex_ovf    = 1'b0;
              end else begin
                lstate_next.xor_sum = cur.xor_sum ^ c;
              end
            end else begin
              if (!cur.after_star[1]) begin
                lstate_next.after_star = cur.after_star + 2'd1;
              end
              if (cur.hex_active) begin
                if (!hd[4]) begin
                  lstate_next.hex_active = 1'b0;
                end else if (!cur.hex_ovf) begin
                  if (cur.hex[30:27] != 4'd0) begin
                    lstate_next.hex_ovf = 1'b1;
                  end else begin
                    lstate_next.hex = {cur.hex[26:0], hd[3:0]};
                  end
                end
              end
            end

            if (cur.tag == TAG_GGA && c == CHAR_COMMA) begin
              lstate_next.tag_found = 1'b1;
            end
            lstate_next.tag = {cur.tag[15:0], c};

            if (cur.commas == FIELD_FIX) begin
              if (!f6.cand && c != CHAR_COMMA) begin
                f6.cand   = 1'b1;
                f6.active = 1'b1;
              end
              lstate_next.f6 = dec_step(f6, c);
            end else if (cur.commas == FIELD_SATS) begin
              lstate_next.f7 = dec_step(cur.f7, c);
            end

            if (c == CHAR_COMMA && cur.commas != FIELD_SATS) begin
              lstate_next.commas = cur.commas + 3'd1;
              if (cur.commas == FIELD_FIX) begin
                lstate_next.f7 = '{cand: 1'b0, active: 1'b1, num: 14'd0};
              end
            end
          end
        end
      end
    end else if (ctrl.produce) begin
      if (valid && cnt_cur != 16'hFFFF) begin
        sentence_counter_next = cnt_cur + 16'd1;
      end
      if (gga) begin
        if (cur.commas == FIELD_SATS) begin
          satellites_held_next = {1'b0, cur.f7.num};
        end
        if (fix_held[14] && (cur.commas == FIELD_FIX ||
            (cur.commas == FIELD_SATS && cur.f6.cand))) begin
          fix_held_next = {1'b0, cur.f6.num};
        end
      end
      lstate_next = '0;
    end

    result.sentence_valid  = valid;
    result.is_position_fix = gga;
    result.valid_count     = sentence_counter_next;
    result.satellites      = satellites_held_next;
    result.fix_quality     = fix_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lstate           <= '0;
      sentence_counter <= 16'd0;
      satellites_held  <= '1;
      fix_held         <= '1;
    end else if (ctrl.take) begin
      lstate           <= lstate_next;
      sentence_counter <= sentence_counter_next;
      satellites_held  <= satellites_held_next;
      fix_held         <= fix_held_next;
    end
  end

  `NMEA_ASSERT_NOW(a_no_result_into_full_slot, ctrl.take && ctrl.produce, out_space, "result taken while output register is full")
  `NMEA_ASSERT_NOW(a_len_bounded, 1'b1, lstate.len <= LEN_LIMIT, "line length above limit")
  `NMEA_ASSERT_NEXT(a_line_cleared, ctrl.take && ctrl.produce, lstate.len == '0, "line not cleared after result")
  `NMEA_ASSERT_NOW(a_after_star_needs_star, lstate.after_star != 2'd0, lstate.star, "characters counted after a missing star")

endmodule

### hw/rtl/nmea_chk_out_stage.sv
module nmea_chk_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  nmea_chk_pkg::core_ctrl_t ctrl,
  input  nmea_chk_pkg::result_t    result,
  output logic                     out_space,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [47:0]              m_axis_tdata,
  output logic [1:0]               m_axis_tuser
);
  import nmea_chk_pkg::*;

  logic    load;
  logic    m_axis_tvalid_next;
  result_t held;

  assign out_space = !m_axis_tvalid || m_axis_tready;
  assign load      = ctrl.take && ctrl.produce;

  always_comb begin
    m_axis_tvalid_next = m_axis_tvalid;
    if (load) begin
      m_axis_tvalid_next = 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= m_axis_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {2'b00, held.fix_quality, held.satellites, held.valid_count};
  assign m_axis_tuser = {held.is_position_fix, held.sentence_valid};

endmodule
